### rtl/dprp_pkg.sv
`default_nettype none
package dprp_pkg;

    localparam int BUF_SIZE_DEFAULT = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam int POS_W            = 32;

    // one classified byte, or a frame end, on its way from front to back
    typedef struct packed {
        logic       end_frame;
        logic       overflow;
        logic       is_zero;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_f;
        logic       is_p;
    } tok_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    position_updated;
        logic                    frame_overflowed;
    } res_t;

endpackage
`default_nettype wire

### rtl/dprp_queue.sv
`default_nettype none
module dprp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/dprp_front.sv
`default_nettype none
module dprp_front #(
    parameter int BUF_SIZE = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    output dprp_pkg::tok_t   tok
);
    import dprp_pkg::*;

    localparam int CNT_W = $clog2(BUF_SIZE);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BUF_SIZE - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_P     = 8'h50;

    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic             is_semi, is_full;
    logic [7:0]       digit_byte;

    assign is_semi    = (rx_byte == CH_SEMI);
    assign is_full    = (frame_count_reg == LAST_CNT);
    assign digit_byte = rx_byte - CH_ZERO;

    always_comb
    begin
        tok.end_frame = is_semi || is_full;
        tok.overflow  = !is_semi;
        tok.is_zero   = (rx_byte == CH_NUL);
        tok.is_space  = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
        tok.is_plus   = (rx_byte == CH_PLUS);
        tok.is_minus  = (rx_byte == CH_MINUS);
        tok.is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        tok.digit     = digit_byte[3:0];
        tok.is_f      = (rx_byte == CH_F);
        tok.is_p      = (rx_byte == CH_P);
    end

    always_comb
    begin
        frame_count_next = frame_count_reg;
        if (accept)
        begin
            frame_count_next = tok.end_frame ? '0 : frame_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/dprp_back.sv
`default_nettype none
module dprp_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        tok_valid,
    input  wire dprp_pkg::tok_t tok,
    output logic             tok_pop,
    input  wire logic        res_full,
    output logic             res_push,
    output dprp_pkg::res_t   res
);
    import dprp_pkg::*;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    localparam logic [POS_W-1:0] MAG_LIMIT = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam int               PROD_W    = POS_W + 4;

    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [POS_W-1:0] mag_reg, mag_next;
    logic             digit_seen_reg, digit_seen_next;
    logic             prev_f_reg, prev_f_next;
    logic             echo_reg, echo_next;
    logic             text_ended_reg, text_ended_next;
    logic [POS_W-1:0] stored_reg, stored_next;

    logic [PROD_W-1:0] mag_ext, prod;
    logic [POS_W-1:0]  mag_taken;
    logic [POS_W-1:0]  value;
    logic              updated;

    // m*10 + d, saturated at 2^31
    assign mag_ext   = {4'b0, mag_reg};
    assign prod      = (mag_ext << 3) + (mag_ext << 1) + {{(PROD_W-4){1'b0}}, tok.digit};
    assign mag_taken = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[POS_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            value = mag_reg[POS_W-1] ? MAG_LIMIT : (~mag_reg + 1'b1);
        end
        else
        begin
            value = mag_reg[POS_W-1] ? POS_MAX : mag_reg;
        end
    end

    assign tok_pop  = tok_valid && (!tok.end_frame || !res_full);
    assign res_push = tok_pop && tok.end_frame;
    assign updated  = digit_seen_reg && !echo_reg;

    always_comb
    begin
        res.position         = updated ? value : stored_reg;
        res.position_updated = updated;
        res.frame_overflowed = tok.overflow;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        digit_seen_next = digit_seen_reg;
        prev_f_next     = prev_f_reg;
        echo_next       = echo_reg;
        text_ended_next = text_ended_reg;
        stored_next     = stored_reg;
        if (tok_pop)
        begin
            if (tok.end_frame)
            begin
                stored_next     = res.position;
                phase_next      = PH_SPACE;
                neg_next        = 1'b0;
                mag_next        = '0;
                digit_seen_next = 1'b0;
                prev_f_next     = 1'b0;
                echo_next       = 1'b0;
                text_ended_next = 1'b0;
            end
            else if (!text_ended_reg)
            begin
                if (tok.is_zero)
                begin
                    text_ended_next = 1'b1;
                end
                else
                begin
                    if (prev_f_reg && tok.is_p)
                    begin
                        echo_next = 1'b1;
                    end
                    prev_f_next = tok.is_f;
                    case (phase_reg)
                        PH_SPACE:
                        begin
                            if (tok.is_space)
                            begin
                                phase_next = PH_SPACE;
                            end
                            else if (tok.is_plus || tok.is_minus)
                            begin
                                neg_next   = tok.is_minus;
                                phase_next = PH_SIGN;
                            end
                            else if (tok.is_digit)
                            begin
                                mag_next        = mag_taken;
                                digit_seen_next = 1'b1;
                                phase_next      = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_SIGN, PH_DIGITS:
                        begin
                            if (tok.is_digit)
                            begin
                                mag_next        = mag_taken;
                                digit_seen_next = 1'b1;
                                phase_next      = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SPACE;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            digit_seen_reg <= 1'b0;
            prev_f_reg     <= 1'b0;
            echo_reg       <= 1'b0;
            text_ended_reg <= 1'b0;
            stored_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            digit_seen_reg <= digit_seen_next;
            prev_f_reg     <= prev_f_next;
            echo_reg       <= echo_next;
            text_ended_reg <= text_ended_next;
            stored_reg     <= stored_next;
        end
    end

    // magnitude never goes past the saturation point
    mag_limit_a: assert property (@(posedge clk) disable iff (!rst_n)
        mag_reg <= MAG_LIMIT)
        else $error("magnitude beyond saturation");

    // still skipping whitespace means nothing has been gathered yet
    space_clean_a: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SPACE) |-> (!digit_seen_reg && mag_reg == '0 && !neg_reg))
        else $error("whitespace phase with gathered value");

    // digits phase always has a digit behind it
    digits_seen_a: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS) |-> digit_seen_reg)
        else $error("digits phase without a digit");

    // a frame end clears the scan for the next frame
    end_clears_a: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == PH_SPACE && !text_ended_reg && !echo_reg))
        else $error("scan not cleared after frame end");

endmodule
`default_nettype wire

### rtl/drive_position_reply_parser.sv
// channel   | transfer on           | payload
// ----------+-----------------------+--------------------------------------------
// bytes in  | push && !full         | rx_byte
// result out| pop && !empty         | position, position_updated, frame_overflowed
//
// one byte is taken every cycle that full is low; the back end consumes one classified
// byte a cycle; a frame end waits while the result queue is full, then queues a result
// full only rises when the two-entry byte queue backs up behind a stalled result queue
// reset clears the frame count, the scan state, the stored position and both queues
// no clearing pass: the block takes bytes in the first cycle after reset
`default_nettype none
module drive_position_reply_parser #(
    parameter int BUF_SIZE = dprp_pkg::BUF_SIZE_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    rx_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [dprp_pkg::POS_W-1:0]  position,
    output logic                               position_updated,
    output logic                               frame_overflowed
);
    import dprp_pkg::*;

    localparam int TOK_W = $bits(tok_t);
    localparam int RES_W = $bits(res_t);

    tok_t             front_tok;
    logic [TOK_W-1:0] tok_q_data;
    tok_t             back_tok;
    logic             tok_q_empty;
    logic             tok_pop;
    logic             accept;

    res_t             back_res;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_q_data;
    res_t             out_res;

    // a byte transfer happens whenever push is high and the byte queue has room
    assign accept = push && !full;

    // front: frame length count and byte classification
    dprp_front #(
        .BUF_SIZE (BUF_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .tok     (front_tok)
    );

    // short queue of classified bytes between front and back
    dprp_queue #(
        .WIDTH (TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_tok),
        .full    (full),
        .pop     (tok_pop),
        .empty   (tok_q_empty),
        .rd_data (tok_q_data)
    );

    assign back_tok = tok_t'(tok_q_data);

    // back: decimal scan, saturation, echo marker search and the stored position
    dprp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!tok_q_empty),
        .tok       (back_tok),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // result queue: lets the back end keep scanning while a result waits
    dprp_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res_q_data)
    );

    assign out_res          = res_t'(res_q_data);
    assign position         = out_res.position;
    assign position_updated = out_res.position_updated;
    assign frame_overflowed = out_res.frame_overflowed;

endmodule
`default_nettype wire
